/* rtl/core/mtg_pkg.sv */
// shared constants and types of the mt19937 word generator
package mtg_pkg;

  localparam int unsigned TABLE_WORDS = 624;
  localparam int unsigned TWIST_SHIFT = 397;
  localparam int unsigned IDX_W       = 10;

  localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

  // command carried in tuser
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef enum logic [1:0] {
    ST_READY,
    ST_SEED,
    ST_DRAW
  } mtg_state_e;

endpackage

/* rtl/core/mtg_cell.sv */
// one state word of the twist chain, loads its neighbor's word on shift
module mtg_cell (
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic [31:0] word_i,
  output logic [31:0] word_o
);

  logic [31:0] word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

/* rtl/core/mtg_twist.sv */
// incremental twist of one state word and output tempering
module mtg_twist (
  input  logic [31:0] first_i,
  input  logic [31:0] second_i,
  input  logic [31:0] far_i,
  output logic [31:0] twisted_o,
  output logic [31:0] tempered_o
);

  logic [31:0] y;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;

  always_comb begin
    y         = (first_i & mtg_pkg::HIGH_BIT) | (second_i & mtg_pkg::LOW_BITS);
    twisted_o = far_i ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_XOR : 32'h0);
    t1         = twisted_o ^ (twisted_o >> 11);
    t2         = t1 ^ ((t1 << 7) & mtg_pkg::TEMPER_B);
    t3         = t2 ^ ((t2 << 15) & mtg_pkg::TEMPER_C);
    tempered_o = t3 ^ (t3 >> 18);
  end

endmodule

/* rtl/core/mt19937_generator.sv */
// mt19937 generator top level: cell chain, seed sequencer and output register
//
// Input words arrive on s_axis: tuser is the command (0 = draw, 1 = reseed),
// tdata is the 32-bit seed, used only for a reseed. Each draw gives one
// tempered 32-bit word on m_axis; a reseed gives none.
// The state is a chain of 624 word cells that shifts by one on every draw:
// the word leaving the head is replaced at the tail by its twisted value,
// which is also tempered into the output register. A draw is done in the
// cycle it is accepted and its word shows on m_axis in the next cycle, so
// draws sustain one word per cycle while the receiver does not stall.
// A reseed pushes the 624 seeded words through the chain, one per cycle
// (one 32x32 multiply and add per word), so it blocks s_axis until the fill ends.
// After reset the block is unseeded; a draw before any reseed seeds with 5489
// first, so the output register loads only after that fill and the ST_DRAW
// state, instead of in the accepting cycle.
// When the receiver stalls, the word waits in the output register and
// s_axis_tready stays low until the word is taken; in the cycle it is taken
// s_axis_tready follows m_axis_tready.
module mt19937_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] seed_value
  input  logic        s_axis_tuser,  // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [31:0] random_word
);

  localparam int unsigned LastCell = mtg_pkg::TABLE_WORDS - 1;

  mtg_pkg::mtg_state_e state_q, state_d;
  logic [mtg_pkg::IDX_W-1:0] seed_cnt_q, seed_cnt_d;
  logic [31:0] seed_val_q, seed_val_d;
  logic        seeded_q, seeded_d;
  logic        pend_q, pend_d;
  logic        out_valid_q;
  logic [31:0] out_data_q;

  logic        out_free;
  logic        s_fire;
  logic        draw_fire;
  logic        shift;
  logic [31:0] feed;
  logic [31:0] seed_mix;
  logic [31:0] seed_next;
  logic [31:0] twisted;
  logic [31:0] tempered;

  logic [31:0] chain_w [mtg_pkg::TABLE_WORDS];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == mtg_pkg::ST_READY) && out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // tail feed: seeded words during a fill, twisted word on a draw
  assign seed_mix  = chain_w[LastCell] ^ (chain_w[LastCell] >> 30);
  assign seed_next = seed_mix * mtg_pkg::SEED_MULT
                   + {{(32 - mtg_pkg::IDX_W){1'b0}}, seed_cnt_q};
  assign feed = (state_q == mtg_pkg::ST_SEED)
              ? ((seed_cnt_q == '0) ? seed_val_q : seed_next)
              : twisted;
  assign shift = (state_q == mtg_pkg::ST_SEED) || draw_fire;

  for (genvar i = 0; i < mtg_pkg::TABLE_WORDS; i++) begin : g_cell
    logic [31:0] cell_in;
    if (i == LastCell) begin : g_tail
      assign cell_in = feed;
    end else begin : g_body
      assign cell_in = chain_w[i+1];
    end
    mtg_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .word_i  (cell_in),
      .word_o  (chain_w[i])
    );
  end

  mtg_twist u_twist (
    .first_i    (chain_w[0]),
    .second_i   (chain_w[1]),
    .far_i      (chain_w[mtg_pkg::TWIST_SHIFT]),
    .twisted_o  (twisted),
    .tempered_o (tempered)
  );

  always_comb begin
    state_d    = state_q;
    seed_cnt_d = seed_cnt_q;
    seed_val_d = seed_val_q;
    seeded_d   = seeded_q;
    pend_d     = pend_q;
    draw_fire  = 1'b0;
    unique case (state_q)
      mtg_pkg::ST_READY: begin
        if (s_fire) begin
          if (s_axis_tuser == mtg_pkg::CMD_SEED) begin
            state_d    = mtg_pkg::ST_SEED;
            seed_cnt_d = '0;
            seed_val_d = s_axis_tdata;
            seeded_d   = 1'b1;
            pend_d     = 1'b0;
          end else if (!seeded_q) begin
            // draw before any seed: self-seed, then draw
            state_d    = mtg_pkg::ST_SEED;
            seed_cnt_d = '0;
            seed_val_d = mtg_pkg::DEFAULT_SEED;
            seeded_d   = 1'b1;
            pend_d     = 1'b1;
          end else begin
            draw_fire = 1'b1;
          end
        end
      end
      mtg_pkg::ST_SEED: begin
        seed_cnt_d = seed_cnt_q + 1'b1;
        if (seed_cnt_q == mtg_pkg::IDX_W'(LastCell)) begin
          state_d = pend_q ? mtg_pkg::ST_DRAW : mtg_pkg::ST_READY;
        end
      end
      mtg_pkg::ST_DRAW: begin
        if (out_free) begin
          draw_fire = 1'b1;
          pend_d    = 1'b0;
          state_d   = mtg_pkg::ST_READY;
        end
      end
      default: begin
        state_d = mtg_pkg::ST_READY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mtg_pkg::ST_READY;
      seed_cnt_q <= '0;
      seeded_q   <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      seed_cnt_q <= seed_cnt_d;
      seeded_q   <= seeded_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_val_q <= seed_val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (draw_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_fire) begin
      out_data_q <= tempered;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a seed command always starts a fill that blocks the input
  a_seed_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == mtg_pkg::CMD_SEED) |=> !s_axis_tready)
    else $error("input not blocked after seed command");

  // the seed counter never runs past the table
  a_seed_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtg_pkg::ST_SEED) |-> (seed_cnt_q < mtg_pkg::IDX_W'(mtg_pkg::TABLE_WORDS)))
    else $error("seed counter out of range");

  // a draw never overwrites a word still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_fire |-> (!out_valid_q || m_axis_tready))
    else $error("draw overwrote pending word");

  // an output word appears only after a draw
  a_word_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(draw_fire))
    else $error("output word without draw");

endmodule
